@@ src/ffcd_pkg.sv @@
// Shared constants, types and reset values for the floor and fault code display.
package ffcd_pkg;

    // Number of fault bits in the fault mask and the width of a fault index.
    localparam int FAULT_BITS  = 11;
    localparam int FAULT_IDX_W = $clog2(FAULT_BITS);
    // The shown fault index carries one extra sign bit so that it can hold minus one.
    localparam int SHOWN_W     = FAULT_IDX_W + 1;

    // Field widths.
    localparam int DIGIT_W     = 5;
    localparam int DWELL_W     = 4;
    localparam int FLOOR_W     = 8;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LETTER = 2'd2;

    // Configuration reset values.
    localparam logic [DWELL_W-1:0] DWELL_RESET        = 4'd10;
    localparam logic [DIGIT_W-1:0] MINUS_CODE_RESET   = 5'd20;
    localparam logic [DIGIT_W-1:0] ERROR_LETTER_RESET = 5'd14;

    // Floor clamp limits.
    localparam logic signed [FLOOR_W-1:0] FLOOR_MIN = -8'sd9;
    localparam logic signed [FLOOR_W-1:0] FLOOR_MAX = 8'sd99;

    // Shown fault value before any fault has been shown.
    localparam logic signed [SHOWN_W-1:0] SHOWN_NONE = '1;

    // Result of the fault bit search.
    typedef struct packed {
        logic                   found;
        logic [FAULT_IDX_W-1:0] index;
    } fault_pick_t;

    // One display word as it leaves the engine.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_high;
        logic [DIGIT_W-1:0] digit_low;
        logic               floor_light;
        logic               fault_light;
    } disp_word_t;

endpackage

@@ src/ffcd_tick_if.sv @@
// Input channel interface: one display tick per transaction.
interface ffcd_tick_if;
    import ffcd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      fault_active;
    logic signed [FLOOR_W-1:0] floor_number;
    logic [FAULT_BITS-1:0]     fault_mask;

    modport source (output valid, output fault_active, output floor_number,
                    output fault_mask, input ready);
    modport sink   (input valid, input fault_active, input floor_number,
                    input fault_mask, output ready);
endinterface

@@ src/ffcd_disp_if.sv @@
// Output channel interface: one display word per transaction.
interface ffcd_disp_if;
    import ffcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit_high;
    logic [DIGIT_W-1:0] digit_low;
    logic               floor_light;
    logic               fault_light;

    modport source (output valid, output digit_high, output digit_low,
                    output floor_light, output fault_light, input ready);
    modport sink   (input valid, input digit_high, input digit_low,
                    input floor_light, input fault_light, output ready);
endinterface

@@ src/ffcd_fault_pick.sv @@
// Fault bit search: picks the next set fault bit above the one shown, with wrap.
module ffcd_fault_pick (
    input  logic [ffcd_pkg::FAULT_BITS-1:0]     fault_mask,
    input  logic signed [ffcd_pkg::SHOWN_W-1:0] shown_fault,
    output ffcd_pkg::fault_pick_t               pick
);
    import ffcd_pkg::*;

    logic                   lowest_found;
    logic [FAULT_IDX_W-1:0] lowest_idx;
    logic                   above_found;
    logic [FAULT_IDX_W-1:0] above_idx;
    logic [FAULT_IDX_W-1:0] top_idx;
    logic                   single_bit;
    logic                   wrap_around;

    // Priority encoders for the lowest, highest and first-above set bits.
    always_comb
    begin
        lowest_found = 1'b0;
        lowest_idx   = '0;
        above_found  = 1'b0;
        above_idx    = '0;
        top_idx      = '0;
        for (int i = 0; i < FAULT_BITS; i++)
        begin
            if (fault_mask[i])
            begin
                top_idx = FAULT_IDX_W'(i);
                if (!lowest_found)
                begin
                    lowest_found = 1'b1;
                    lowest_idx   = FAULT_IDX_W'(i);
                end
                if (!above_found && (shown_fault[SHOWN_W-1] ||
                    FAULT_IDX_W'(i) > shown_fault[FAULT_IDX_W-1:0]))
                begin
                    above_found = 1'b1;
                    above_idx   = FAULT_IDX_W'(i);
                end
            end
        end
    end

    // A single set bit, or the highest bit already shown, wraps to the lowest bit.
    assign single_bit  = (fault_mask != '0) &&
                         ((fault_mask & (fault_mask - FAULT_BITS'(1))) == '0);
    assign wrap_around = single_bit || (shown_fault == $signed({1'b0, top_idx}));

    always_comb
    begin
        if (wrap_around)
        begin
            pick.found = lowest_found;
            pick.index = lowest_idx;
        end
        else
        begin
            pick.found = above_found;
            pick.index = above_idx;
        end
    end

endmodule

@@ src/ffcd_engine.sv @@
// Display engine: floor decode, dwell counter, fault selection and held digits.
module ffcd_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                fault_active,
    input  logic signed [ffcd_pkg::FLOOR_W-1:0] floor_number,
    input  logic [ffcd_pkg::FAULT_BITS-1:0]     fault_mask,
    input  logic [ffcd_pkg::DWELL_W-1:0]        dwell_ticks,
    input  logic [ffcd_pkg::DIGIT_W-1:0]        minus_code,
    input  logic [ffcd_pkg::DIGIT_W-1:0]        error_letter_code,
    output ffcd_pkg::disp_word_t                word_next
);
    import ffcd_pkg::*;

    logic signed [SHOWN_W-1:0] shown_fault_reg, shown_fault_next;
    logic [DWELL_W-1:0]        dwell_count_reg, dwell_count_next;
    logic [DIGIT_W-1:0]        held_high_reg, held_high_next;
    logic [DIGIT_W-1:0]        held_low_reg, held_low_next;

    logic signed [FLOOR_W-1:0] floor_clamped;
    logic [FLOOR_W-1:0]        floor_mag;
    logic [6:0]                floor_pos;
    logic [14:0]               tens_prod;
    logic [3:0]                tens;
    logic [6:0]                units;
    logic                      dwell_update;
    fault_pick_t               pick;

    ffcd_fault_pick u_pick (
        .fault_mask  (fault_mask),
        .shown_fault (shown_fault_reg),
        .pick        (pick)
    );

    // Clamp the floor to the displayable range.
    always_comb
    begin
        priority if (floor_number < FLOOR_MIN)
            floor_clamped = FLOOR_MIN;
        else if (floor_number > FLOOR_MAX)
            floor_clamped = FLOOR_MAX;
        else
            floor_clamped = floor_number;
    end

    // Split a floor of 0..99 into tens and units by a reciprocal multiply.
    assign floor_pos = floor_clamped[6:0];
    assign tens_prod = 15'(floor_pos) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign units     = floor_pos - (7'(tens) * 7'd10);
    assign floor_mag = FLOOR_W'(-floor_clamped);

    // Fault ticks advance only at the end of a dwell period.
    assign dwell_update = (dwell_count_reg == '0) || (dwell_count_reg == dwell_ticks);

    // Next state and displayed digits for the current tick.
    always_comb
    begin
        shown_fault_next = shown_fault_reg;
        dwell_count_next = dwell_count_reg;
        held_high_next   = held_high_reg;
        held_low_next    = held_low_reg;
        if (!fault_active)
        begin
            if (floor_clamped[FLOOR_W-1])
            begin
                held_high_next = minus_code;
                held_low_next  = floor_mag[DIGIT_W-1:0];
            end
            else
            begin
                held_high_next = DIGIT_W'(tens);
                held_low_next  = units[DIGIT_W-1:0];
            end
        end
        else if (dwell_update)
        begin
            dwell_count_next = DWELL_W'(1);
            if (pick.found)
            begin
                held_high_next   = error_letter_code;
                held_low_next    = DIGIT_W'(pick.index);
                shown_fault_next = $signed({1'b0, pick.index});
            end
        end
        else
        begin
            dwell_count_next = dwell_count_reg + DWELL_W'(1);
        end
    end

    assign word_next.digit_high  = held_high_next;
    assign word_next.digit_low   = held_low_next;
    assign word_next.floor_light = !fault_active;
    assign word_next.fault_light = fault_active;

    // State registers advance once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_fault_reg <= SHOWN_NONE;
            dwell_count_reg <= '0;
            held_high_reg   <= '0;
            held_low_reg    <= '0;
        end
        else if (en)
        begin
            shown_fault_reg <= shown_fault_next;
            dwell_count_reg <= dwell_count_next;
            held_high_reg   <= held_high_next;
            held_low_reg    <= held_low_next;
        end
    end

    // A dwell update always restarts the count at one.
    a_dwell_restart: assert property (@(posedge clk) disable iff (!rst_n)
        en && fault_active && dwell_update |=> dwell_count_reg == DWELL_W'(1))
        else $error("dwell count did not restart after an update");

    // The shown fault is either none or a valid fault number.
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        shown_fault_reg == SHOWN_NONE ||
        (!shown_fault_reg[SHOWN_W-1] && shown_fault_reg < $signed(SHOWN_W'(FAULT_BITS))))
        else $error("shown fault out of range");

    // A floor tick leaves the fault tracking untouched.
    a_floor_holds: assert property (@(posedge clk) disable iff (!rst_n)
        en && !fault_active |=> $stable(shown_fault_reg) && $stable(dwell_count_reg))
        else $error("floor tick changed fault tracking");

endmodule

@@ src/floor_and_fault_code_display.sv @@
// Top level of the floor and fault code display: handshake stages and config registers.
//
// Usage:
//   tick  (sink)   : one display tick per transaction, carrying fault_active,
//                    floor_number and fault_mask.
//   disp  (source) : one display word per tick, carrying digit_high, digit_low,
//                    floor_light and fault_light.
//   cfg_we / cfg_index / cfg_data : write port for dwell_ticks (index 0),
//                    minus_code (index 1) and error_letter_code (index 2);
//                    write it only while no tick is in flight.
// Path: an accepted tick is held in the input register, and its display word is
//   loaded into the output register once the output stage is empty or taken;
//   the word is then valid on disp.
// Throughput: one tick per cycle while disp does not stall; the floor decode, the
//   fault bit search and the dwell counter are all combinational between the two registers.
// Reset clears both pipeline stages, restores the register reset values
//   (dwell 10, minus code 20, error letter 14) and clears the display state.
// When the receiver stalls, the output word holds; one more tick is taken into
//   the input register, after which tick.ready falls until disp drains.
module floor_and_fault_code_display (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ffcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffcd_pkg::CFG_DATA_W-1:0]    cfg_data,
    ffcd_tick_if.sink                          tick,
    ffcd_disp_if.source                        disp
);
    import ffcd_pkg::*;

    logic [DWELL_W-1:0]        dwell_ticks_reg;
    logic [DIGIT_W-1:0]        minus_code_reg;
    logic [DIGIT_W-1:0]        error_letter_reg;

    logic                      in_valid_reg, in_valid_next;
    logic                      in_fault_reg;
    logic signed [FLOOR_W-1:0] in_floor_reg;
    logic [FAULT_BITS-1:0]     in_mask_reg;

    logic                      out_valid_reg, out_valid_next;
    disp_word_t                out_word_reg;
    disp_word_t                word_next;

    logic                      out_adv;
    logic                      proc_en;
    logic                      tick_take;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg  <= DWELL_RESET;
            minus_code_reg   <= MINUS_CODE_RESET;
            error_letter_reg <= ERROR_LETTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DWELL_TICKS:  dwell_ticks_reg  <= cfg_data[DWELL_W-1:0];
                CFG_MINUS_CODE:   minus_code_reg   <= cfg_data[DIGIT_W-1:0];
                CFG_ERROR_LETTER: error_letter_reg <= cfg_data[DIGIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stage control: the output stage frees up when empty or taken.
    assign out_adv    = !out_valid_reg || disp.ready;
    assign proc_en    = in_valid_reg && out_adv;
    assign tick.ready = !in_valid_reg || out_adv;
    assign tick_take  = tick.valid && tick.ready;

    assign in_valid_next  = tick.ready ? tick.valid : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            in_fault_reg <= tick.fault_active;
            in_floor_reg <= tick.floor_number;
            in_mask_reg  <= tick.fault_mask;
        end
    end

    ffcd_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (proc_en),
        .fault_active      (in_fault_reg),
        .floor_number      (in_floor_reg),
        .fault_mask        (in_mask_reg),
        .dwell_ticks       (dwell_ticks_reg),
        .minus_code        (minus_code_reg),
        .error_letter_code (error_letter_reg),
        .word_next         (word_next)
    );

    // Output register loads the processed display word.
    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            out_word_reg <= word_next;
        end
    end

    assign disp.valid       = out_valid_reg;
    assign disp.digit_high  = out_word_reg.digit_high;
    assign disp.digit_low   = out_word_reg.digit_low;
    assign disp.floor_light = out_word_reg.floor_light;
    assign disp.fault_light = out_word_reg.fault_light;

    // A processed tick always lands in the output stage.
    a_proc_lands: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en |=> out_valid_reg)
        else $error("processed tick did not reach the output stage");

    // A new transaction never overwrites a tick that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tick_take |-> (!in_valid_reg || proc_en))
        else $error("input register overwritten before processing");

    // Exactly one indicator light is on in every valid display word.
    a_one_light: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.floor_light != out_word_reg.fault_light))
        else $error("indicator lights inconsistent");

endmodule

@@ tb/ffcd_display_checker.sv @@
// Checker for the floor and fault code display: tracks settings, predicts words, compares.
module ffcd_display_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffcd_pkg::CFG_DATA_W-1:0] cfg_data,
    ffcd_tick_if                            tick,
    ffcd_disp_if                            disp,
    output int                              mismatches,
    output int                              outstanding
);
    import ffcd_pkg::*;

    // Register copies as last written through the write port.
    logic [DWELL_W-1:0] dwell_cfg;
    logic [DIGIT_W-1:0] minus_cfg;
    logic [DIGIT_W-1:0] letter_cfg;

    // Display state: fault index on show (minus one for none), dwell counter, held digits.
    int                 last_fault;
    logic [DWELL_W-1:0] dwell_cnt;
    logic [DIGIT_W-1:0] held_high;
    logic [DIGIT_W-1:0] held_low;

    // Display words owed for accepted ticks, oldest first.
    disp_word_t pending_words[$];

    // Works out the display word for one tick and advances the display state.
    function automatic disp_word_t next_display(input logic fault,
                                                input logic signed [FLOOR_W-1:0] floor_in,
                                                input logic [FAULT_BITS-1:0] mask);
        int         level;
        int         set_count;
        int         top;
        int         lowest;
        int         above;
        disp_word_t word;
        if (!fault)
        begin
            // Clamp the floor and split it into two digits.
            level = floor_in;
            if (level < -9)
                level = -9;
            if (level > 99)
                level = 99;
            if (level >= 0)
            begin
                held_high = DIGIT_W'(level / 10);
                held_low  = DIGIT_W'(level % 10);
            end
            else
            begin
                held_high = minus_cfg;
                held_low  = DIGIT_W'(-level);
            end
        end
        else if (dwell_cnt == '0 || dwell_cnt == dwell_cfg)
        begin
            // Dwell period over: search for the next set fault bit.
            dwell_cnt = DWELL_W'(1);
            set_count = 0;
            top       = 0;
            lowest    = -1;
            above     = -1;
            for (int i = 0; i < FAULT_BITS; i++)
            begin
                if (mask[i])
                begin
                    set_count++;
                    top = i;
                    if (lowest < 0)
                        lowest = i;
                    if (above < 0 && i > last_fault)
                        above = i;
                end
            end
            if (set_count == 1 || last_fault == top)
            begin
                if (lowest >= 0)
                begin
                    held_high  = letter_cfg;
                    held_low   = DIGIT_W'(lowest);
                    last_fault = lowest;
                end
            end
            else if (above >= 0)
            begin
                held_high  = letter_cfg;
                held_low   = DIGIT_W'(above);
                last_fault = above;
            end
        end
        else
        begin
            // The counter wraps through zero at its width.
            dwell_cnt = dwell_cnt + 1'b1;
        end
        word.digit_high  = held_high;
        word.digit_low   = held_low;
        word.floor_light = !fault;
        word.fault_light = fault;
        return word;
    endfunction

    task automatic check_field(input string name, input logic [DIGIT_W-1:0] want,
                               input logic [DIGIT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare finished words first, then queue the prediction for a new tick.
    always @(posedge clk or negedge rst_n)
    begin
        disp_word_t want;
        if (!rst_n)
        begin
            dwell_cfg   = DWELL_RESET;
            minus_cfg   = MINUS_CODE_RESET;
            letter_cfg  = ERROR_LETTER_RESET;
            last_fault  = -1;
            dwell_cnt   = '0;
            held_high   = '0;
            held_low    = '0;
            mismatches  = 0;
            pending_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (disp.valid && disp.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("display word with no tick waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    check_field("digit_high", want.digit_high, disp.digit_high);
                    check_field("digit_low", want.digit_low, disp.digit_low);
                    check_field("floor_light", DIGIT_W'(want.floor_light),
                                DIGIT_W'(disp.floor_light));
                    check_field("fault_light", DIGIT_W'(want.fault_light),
                                DIGIT_W'(disp.fault_light));
                end
            end
            if (tick.valid && tick.ready)
                pending_words.push_back(next_display(tick.fault_active, tick.floor_number,
                                                     tick.fault_mask));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DWELL_TICKS:  dwell_cfg  = cfg_data[DWELL_W-1:0];
                    CFG_MINUS_CODE:   minus_cfg  = cfg_data[DIGIT_W-1:0];
                    CFG_ERROR_LETTER: letter_cfg = cfg_data[DIGIT_W-1:0];
                    default:          ;
                endcase
            end
            outstanding <= pending_words.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the floor and fault code display: stimulus, clock, reset and verdict.
module tb;
    import ffcd_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int PHASES     = 6;
    localparam int PHASE_TICKS = 92;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int outstanding;

    // Per-phase idle pattern and register settings; the last phase draws its settings.
    int idle_plan[PHASES]   = '{0, 63, 0, 11, 0, 63};
    int stall_plan[PHASES]  = '{0, 0, 63, 11, 0, 0};
    int dwell_plan[PHASES]  = '{15, 2, 0, 1, 7, 3};
    int minus_plan[PHASES]  = '{28, 0, 3, 17, 9, 20};
    int letter_plan[PHASES] = '{0, 28, 11, 5, 22, 14};

    ffcd_tick_if tick();
    ffcd_disp_if disp();

    floor_and_fault_code_display i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .disp      (disp)
    );

    ffcd_display_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick        (tick),
        .disp        (disp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: stalls at random at the current phase's rate.
    always @(posedge clk)
    begin
        disp.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Offers one tick, after random idle cycles, and returns once it is accepted.
    task automatic send_tick(input logic fault, input logic signed [FLOOR_W-1:0] floor_in,
                             input logic [FAULT_BITS-1:0] mask);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid        <= 1'b1;
        tick.fault_active <= fault;
        tick.floor_number <= floor_in;
        tick.fault_mask   <= mask;
        do
            @(posedge clk);
        while (!tick.ready);
    endtask

    // Stops sending and waits until every owed display word has arrived.
    task automatic drain_display();
        tick.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Writes all three registers on consecutive cycles; the block must be idle.
    task automatic write_config(input logic [DWELL_W-1:0] dwell,
                                input logic [DIGIT_W-1:0] minus,
                                input logic [DIGIT_W-1:0] letter);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DWELL_TICKS;
        cfg_data  <= CFG_DATA_W'(dwell);
        @(posedge clk);
        cfg_index <= CFG_MINUS_CODE;
        cfg_data  <= minus;
        @(posedge clk);
        cfg_index <= CFG_ERROR_LETTER;
        cfg_data  <= letter;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [FAULT_BITS-1:0] random_mask();
        case ($urandom_range(4))
            0:       return '0;
            1:       return FAULT_BITS'(1) << $urandom_range(FAULT_BITS - 1);
            2:       return '1;
            default: return FAULT_BITS'($urandom);
        endcase
    endfunction

    // Mostly fault bursts long enough to cross dwell periods, mixed with floor runs.
    task automatic random_ticks(input int count);
        int                          sent;
        int                          burst;
        logic [FAULT_BITS-1:0]       mask;
        logic signed [FLOOR_W-1:0]   level;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 6)
            begin
                burst = $urandom_range(40, 1);
                if (burst > count - sent)
                    burst = count - sent;
                mask  = random_mask();
                repeat (burst)
                begin
                    if ($urandom_range(19) == 0)
                        mask = random_mask();
                    send_tick(1'b1, FLOOR_W'($urandom), mask);
                    sent++;
                end
            end
            else
            begin
                burst = $urandom_range(6, 1);
                if (burst > count - sent)
                    burst = count - sent;
                repeat (burst)
                begin
                    if ($urandom_range(4) == 0)
                        level = FLOOR_W'($urandom);
                    else
                        level = FLOOR_W'(int'($urandom_range(108)) - 9);
                    send_tick(1'b0, level, FAULT_BITS'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Main stimulus and verdict.
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_DWELL_TICKS;
        cfg_data          <= '0;
        tick.valid        <= 1'b0;
        tick.fault_active <= 1'b0;
        tick.floor_number <= '0;
        tick.fault_mask   <= '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Floor extremes and clamping with the reset settings.
        send_tick(1'b0, 8'sd0, '0);
        send_tick(1'b0, 8'sd9, '0);
        send_tick(1'b0, 8'sd10, '0);
        send_tick(1'b0, 8'sd99, '0);
        send_tick(1'b0, 8'sd127, '1);
        send_tick(1'b0, -8'sd1, '0);
        send_tick(1'b0, -8'sd9, '0);
        send_tick(1'b0, -8'sd10, '0);
        send_tick(1'b0, -8'sd128, '1);
        // Fault with an empty mask and nothing shown yet: the digits hold.
        send_tick(1'b1, 8'sd5, '0);
        drain_display();

        // Dwell of one: advance on every fault tick, wrap from the highest bit.
        write_config(4'd1, 5'd0, 5'd28);
        send_tick(1'b1, 8'sd0, 11'h405);
        send_tick(1'b1, 8'sd0, 11'h405);
        send_tick(1'b1, 8'sd0, 11'h405);
        send_tick(1'b1, 8'sd0, 11'h405);
        send_tick(1'b1, 8'sd0, 11'h7FF);
        send_tick(1'b1, 8'sd0, 11'h7FF);
        // A single set bit is shown directly.
        send_tick(1'b1, 8'sd0, 11'h400);
        // Empty mask after a shown fault: the digits hold.
        send_tick(1'b1, 8'sd0, '0);
        send_tick(1'b0, -8'sd5, '0);
        drain_display();

        // Random phases, each with its own settings and idle pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                write_config(DWELL_W'($urandom_range(15, 2)), DIGIT_W'($urandom_range(28)),
                             DIGIT_W'($urandom_range(28)));
            else
                write_config(DWELL_W'(dwell_plan[p]), DIGIT_W'(minus_plan[p]),
                             DIGIT_W'(letter_plan[p]));
            sender_idle_pct    = idle_plan[p];
            receiver_stall_pct = stall_plan[p];
            random_ticks(PHASE_TICKS);
            drain_display();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #(200_000 * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
